>>> src/q2e_pkg.sv
// Package for the quaternion to Z-Y-X Euler angle block: widths, types, arctangent table.
`default_nettype none
package q2e_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int ATAN_LEN          = 24;
  localparam int SUM_W             = 35;  // Q2.30 sums, doubled, with headroom
  localparam int CW                = 37;  // CORDIC vector coordinate width
  localparam int AW                = 32;  // CORDIC angle, 2^31 = pi
  localparam int SQ_W              = 62;  // square root remainder and root
  localparam int SQRT_STAGES       = 31;  // one root bit per cell
  localparam int LANES             = 3;

  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_ROLL  = 2;

  localparam logic signed [15:0] HALF_PI_BAM = 16'sd16384;

  typedef logic [AW-1:0] atan_tab_t [ATAN_LEN];

  // arctangent of 2^-i, scale 2^31 = pi
  localparam atan_tab_t ATAN_TAB = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670675, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]        z;
    logic                 zero;
  } cordic_lane_t;

  typedef struct packed {
    logic clamped;
    logic neg;
  } pitch_side_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_data_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sp;
    pitch_side_t             ps;
  } sqrt_side_t;

endpackage
`default_nettype wire

>>> src/q2e_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one root bit.
`default_nettype none
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int K = 0
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         en,
  input  wire         valid_in,
  input  sqrt_data_t  data_in,
  input  sqrt_side_t  side_in,
  output logic        valid_out,
  output sqrt_data_t  data_out,
  output sqrt_side_t  side_out
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * K);

  logic       valid_r;
  sqrt_data_t data_r, data_nxt;
  sqrt_side_t side_r;
  logic [SQ_W-1:0] trial;

  // trial subtract of root plus current bit
  always_comb begin
    trial = data_in.res + BIT;
    if (data_in.rem >= trial) begin
      data_nxt.rem = data_in.rem - trial;
      data_nxt.res = (data_in.res >> 1) + BIT;
    end else begin
      data_nxt.rem = data_in.rem;
      data_nxt.res = data_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

>>> src/q2e_cordic_cell.sv
// One CORDIC vectoring micro-rotation for the yaw, pitch and roll lanes.
`default_nettype none
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int I = 0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           valid_in,
  input  cordic_lane_t [LANES-1:0]      lane_in,
  input  pitch_side_t                   side_in,
  output logic                          valid_out,
  output cordic_lane_t [LANES-1:0]      lane_out,
  output pitch_side_t                   side_out
);

  localparam logic [AW-1:0] ATAN_I = ATAN_TAB[I];

  logic                     valid_r;
  cordic_lane_t [LANES-1:0] lane_r, lane_nxt;
  pitch_side_t              side_r;
  logic signed [CW-1:0]     xs [LANES];
  logic signed [CW-1:0]     ys [LANES];

  // rotate towards the x axis
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xs[l] = lane_in[l].x >>> I;
      ys[l] = lane_in[l].y >>> I;
      lane_nxt[l].zero = lane_in[l].zero;
      if (!lane_in[l].y[CW-1]) begin
        lane_nxt[l].x = lane_in[l].x + ys[l];
        lane_nxt[l].y = lane_in[l].y - xs[l];
        lane_nxt[l].z = lane_in[l].z + ATAN_I;
      end else begin
        lane_nxt[l].x = lane_in[l].x - ys[l];
        lane_nxt[l].y = lane_in[l].y + xs[l];
        lane_nxt[l].z = lane_in[l].z - ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign lane_out  = lane_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

>>> src/quaternion_to_euler_zyx.sv
// Top level: quaternion to Z-Y-X Euler angles, fully pipelined.
//
// Input channel in_*: one quaternion (w, x, y, z), Q1.15 each, per item.
// Output channel out_*: yaw, pitch and roll as 16-bit binary angles
// (32768 = pi) and a flag set when pitch was clamped to plus or minus pi/2.
// From acceptance to out_valid an item passes the registers for the products,
// sums, the pitch sine square, 31 square root cells (one root bit each),
// the CORDIC set-up, one CORDIC cell per stage and the output register.
// One item is accepted every cycle while results are taken.
// All stages advance together; when the receiver holds out_ready low with a
// result waiting, the whole pipeline holds and in_ready drops, so nothing
// is lost. A result already in the output register stays unchanged until
// taken. Synchronous reset clears every stage's valid bit; in_ready is low
// while reset is asserted.
`default_nettype none
module quaternion_to_euler_zyx
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [15:0]  in_quat_w,
  input  wire signed [15:0]  in_quat_x,
  input  wire signed [15:0]  in_quat_y,
  input  wire signed [15:0]  in_quat_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle,
  output logic               out_pitch_clamped
);

  localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(1) <<< 30;

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = rst_n && en;

  // stage 1: products
  logic                v1_r;
  logic signed [31:0]  wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
    end
  end

  // stage 2: doubled sums in Q2.30
  logic                    v2_r;
  logic signed [SUM_W-1:0] sr_r, cr_r, sy_r, cy_r, sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
      cr_r <= ONE_Q30 - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1);
      sy_r <= (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
      cy_r <= ONE_Q30 - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1);
      sp_r <= (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
    end
  end

  // stage 3: pitch clamp decision and sine squared
  logic                    clamp_c;
  logic signed [30:0]      spn_c;
  logic                    v3_r;
  logic [SQ_W-1:0]         sq_r;
  sqrt_side_t              side3_r;

  always_comb begin
    clamp_c = (sp_r >= ONE_Q30) || (sp_r <= -ONE_Q30);
    spn_c   = clamp_c ? 31'sd0 : sp_r[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r               <= SQ_W'(spn_c * spn_c);
      side3_r.sr         <= sr_r;
      side3_r.cr         <= cr_r;
      side3_r.sy         <= sy_r;
      side3_r.cy         <= cy_r;
      side3_r.sp         <= sp_r;
      side3_r.ps.clamped <= clamp_c;
      side3_r.ps.neg     <= sp_r[SUM_W-1];
    end
  end

  // square root chain: cos of pitch = sqrt(1 - s^2)
  logic       sq_v [SQRT_STAGES+1];
  sqrt_data_t sq_d [SQRT_STAGES+1];
  sqrt_side_t sq_s [SQRT_STAGES+1];

  assign sq_v[0]     = v3_r;
  assign sq_d[0].rem = (SQ_W'(1) << 60) - sq_r;
  assign sq_d[0].res = '0;
  assign sq_s[0]     = side3_r;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    q2e_sqrt_cell #(.K(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (sq_v[k]),
      .data_in   (sq_d[k]),
      .side_in   (sq_s[k]),
      .valid_out (sq_v[k+1]),
      .data_out  (sq_d[k+1]),
      .side_out  (sq_s[k+1])
    );
  end

  // CORDIC set-up: move the vector into the right half plane
  logic signed [CW-1:0]     px [LANES];
  logic signed [CW-1:0]     py [LANES];
  cordic_lane_t [LANES-1:0] prep_nxt;
  logic                     vp_r;
  cordic_lane_t [LANES-1:0] prep_r;
  pitch_side_t              pside_r;

  always_comb begin
    px[LANE_YAW]   = CW'(sq_s[SQRT_STAGES].cy);
    py[LANE_YAW]   = CW'(sq_s[SQRT_STAGES].sy);
    px[LANE_PITCH] = CW'({1'b0, sq_d[SQRT_STAGES].res[30:0]});
    py[LANE_PITCH] = CW'(sq_s[SQRT_STAGES].sp);
    px[LANE_ROLL]  = CW'(sq_s[SQRT_STAGES].cr);
    py[LANE_ROLL]  = CW'(sq_s[SQRT_STAGES].sr);
    for (int l = 0; l < LANES; l++) begin
      prep_nxt[l].zero = (px[l] == '0) && (py[l] == '0);
      if (px[l][CW-1]) begin
        prep_nxt[l].x = -px[l];
        prep_nxt[l].y = -py[l];
        prep_nxt[l].z = AW'(1) << (AW - 1);
      end else begin
        prep_nxt[l].x = px[l];
        prep_nxt[l].y = py[l];
        prep_nxt[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= sq_v[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r  <= prep_nxt;
      pside_r <= sq_s[SQRT_STAGES].ps;
    end
  end

  // CORDIC chain
  logic                     cd_v [NST+1];
  cordic_lane_t [LANES-1:0] cd_l [NST+1];
  pitch_side_t              cd_s [NST+1];

  assign cd_v[0] = vp_r;
  assign cd_l[0] = prep_r;
  assign cd_s[0] = pside_r;

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    q2e_cordic_cell #(.I(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (cd_v[i]),
      .lane_in   (cd_l[i]),
      .side_in   (cd_s[i]),
      .valid_out (cd_v[i+1]),
      .lane_out  (cd_l[i+1]),
      .side_out  (cd_s[i+1])
    );
  end

  // rounding to 16-bit binary angles and pitch clamp
  logic [AW-1:0]      zr [LANES];
  logic signed [15:0] ang [LANES];
  logic signed [15:0] pitch_c;
  logic signed [15:0] yaw_r, pitch_r, roll_r;
  logic               clamped_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      zr[l]  = cd_l[NST][l].z + AW'(32768);
      ang[l] = cd_l[NST][l].zero ? 16'sd0 : zr[l][AW-1:AW-16];
    end
    if (cd_s[NST].clamped) begin
      pitch_c = cd_s[NST].neg ? -HALF_PI_BAM : HALF_PI_BAM;
    end else if (ang[LANE_PITCH] > HALF_PI_BAM) begin
      pitch_c = HALF_PI_BAM;
    end else if (ang[LANE_PITCH] < -HALF_PI_BAM) begin
      pitch_c = -HALF_PI_BAM;
    end else begin
      pitch_c = ang[LANE_PITCH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cd_v[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r     <= ang[LANE_YAW];
      pitch_r   <= pitch_c;
      roll_r    <= ang[LANE_ROLL];
      clamped_r <= cd_s[NST].clamped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_angle   = pitch_r;
  assign out_roll_angle    = roll_r;
  assign out_pitch_clamped = clamped_r;

endmodule
`default_nettype wire

>>> src/q2e_checker.sv
// Port-level checks for the quaternion to Euler block, bound to the top level.
`default_nettype none
module q2e_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] out_yaw_angle,
  input wire signed [15:0] out_pitch_angle,
  input wire signed [15:0] out_roll_angle,
  input wire               out_pitch_clamped
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw_angle) &&
      $stable(out_pitch_angle) && $stable(out_roll_angle) &&
      $stable(out_pitch_clamped))
    else $error("stalled result changed");

  // an empty output stage always takes an item
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with output empty");

  // clamped pitch sits exactly at a pole
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_clamped |->
      out_pitch_angle == 16'sd16384 || out_pitch_angle == -16'sd16384)
    else $error("clamped pitch not at a pole");

  // pitch stays within a quarter turn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 16'sd16384 && out_pitch_angle >= -16'sd16384)
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_zyx q2e_checker u_q2e_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_yaw_angle     (out_yaw_angle),
  .out_pitch_angle   (out_pitch_angle),
  .out_roll_angle    (out_roll_angle),
  .out_pitch_clamped (out_pitch_clamped)
);
`default_nettype wire

>>> tb/sv/tb_quaternion_to_euler_zyx.sv
// Testbench for quaternion_to_euler_zyx: random and directed quaternions against a predictor.
`default_nettype none
module tb_quaternion_to_euler_zyx
  import q2e_pkg::*;
();

  localparam int STAGES     = DEF_CORDIC_STAGES;
  localparam int LATENCY    = STAGES + 36;
  localparam int N_RANDOM   = 950;
  localparam int CYCLE_CAP  = 400000;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint PI_UNITS = 64'sd1 << 31;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } euler_t;

  int n_mismatch = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    n_mismatch++;
  endtask

  // CORDIC vectoring atan2, angle returned as a 16-bit binary angle
  function automatic logic signed [15:0] cordic_angle(input longint y, input longint x);
    longint acc;
    longint xs;
    longint ys;
    longint r;
    acc = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = PI_UNITS;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    r = (acc + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic euler_t quat_to_euler(input logic signed [15:0] qw,
                                           input logic signed [15:0] qx,
                                           input logic signed [15:0] qy,
                                           input logic signed [15:0] qz);
    longint w, x, y, z, sr, cr, sy, cy, sp, cp;
    logic signed [15:0] a;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q30 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q30 - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (sp >= ONE_Q30) begin
      e.pitch = HALF_PI_BAM;
      e.clamped = 1'b1;
    end else if (sp <= -ONE_Q30) begin
      e.pitch = -HALF_PI_BAM;
      e.clamped = 1'b1;
    end else begin
      cp = int_sqrt((64'sd1 << 60) - sp * sp);
      a = cordic_angle(sp, cp);
      if (a > HALF_PI_BAM) a = HALF_PI_BAM;
      if (a < -HALF_PI_BAM) a = -HALF_PI_BAM;
      e.pitch = a;
    end
    e.yaw = cordic_angle(sy, cy);
    e.roll = cordic_angle(sr, cr);
    return e;
  endfunction

  // scoreboard: angles predicted for accepted quaternions, oldest first
  class angle_board;
    euler_t pending[$];
    int n_checked;

    function void note_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      pending.insert(pending.size(), quat_to_euler(w, x, y, z));
    endfunction

    task check_angles(input euler_t got);
      euler_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
      if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
      if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
      if (got.clamped !== want.clamped)
        report_mismatch("pitch_clamped", got.clamped, want.clamped);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_yaw_angle, out_pitch_angle, out_roll_angle;
  logic out_pitch_clamped;

  angle_board board = new();
  int cycle_count = 0;
  bit sending_done = 1'b0;
  bit hold_off = 1'b0;

  quaternion_to_euler_zyx uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_yaw_angle(out_yaw_angle), .out_pitch_angle(out_pitch_angle),
    .out_roll_angle(out_roll_angle), .out_pitch_clamped(out_pitch_clamped)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // offer one quaternion and hold it until accepted
  task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    in_valid <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    do @(posedge clk); while (!in_ready);
    board.note_quat(w, x, y, z);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // stimulus
  initial begin
    int burst;
    logic signed [15:0] w, x, y, z;
    int c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, zero, extremes, gimbal lock both ways, pi roll/yaw
    send_quat(16'sh7fff, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh5a82, 0, 16'sh5a82, 0);
    send_quat(16'sh5a82, 0, -16'sh5a82, 0);
    send_quat(16'sh7fff, 0, 16'sh7fff, 0);
    send_quat(16'sh7fff, 0, 16'sh8000, 0);
    send_quat(0, 16'sh7fff, 0, 0);
    send_quat(0, 0, 0, 16'sh7fff);
    send_quat(0, 16'sh8000, 0, 0);
    send_quat(0, 0, 16'sh7fff, 0);
    send_quat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
    send_quat(16'sh4000, -16'sh4000, 16'sh4000, -16'sh4000);
    send_quat(16'sh0001, 16'shffff, 16'sh0001, 16'shffff);
    send_quat(16'sh8000, 0, 0, 0);
    idle_sender(3);

    // random bursts; components within +/-23170 most of the time
    c = 0;
    while (c < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && c < N_RANDOM; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          w = 16'($urandom_range(0, 46340) - 23170);
          x = 16'($urandom_range(0, 46340) - 23170);
          y = 16'($urandom_range(0, 46340) - 23170);
          z = 16'($urandom_range(0, 46340) - 23170);
        end else begin
          w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
        end
        send_quat(w, x, y, z);
        c++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: own stall pattern, plus one long hold-off early in the run
  initial begin
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    hold_off = 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    euler_t got;
    if (out_valid && out_ready) begin
      got.yaw = out_yaw_angle;
      got.pitch = out_pitch_angle;
      got.roll = out_roll_angle;
      got.clamped = out_pitch_clamped;
      board.check_angles(got);
    end
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if ((cycle_count % 256) < 80) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // end of run and cycle limit
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_quaternion_to_euler_zyx: FAIL");
        $finish;
      end
      if (sending_done && board.pending.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d results from directed and random quaternions,", board.n_checked);
        $display("including gimbal lock, zero and full-scale inputs and a long output stall");
        if (n_mismatch == 0 && board.pending.size() == 0)
          $display("tb_quaternion_to_euler_zyx: PASS");
        else
          $display("tb_quaternion_to_euler_zyx: FAIL");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
